// ----- design/param_frame_receiver_defines.svh -----
// ----------------------------------------------------------------------------
// Parameter frame receiver assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PARAM_FRAME_RECEIVER_DEFINES_SVH
`define PARAM_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define PFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Constants and types shared by the parameter frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int FrameLen   = 23;
    localparam int SumPos     = 22;
    localparam int NumWords   = 9;
    localparam int QueueDepth = 2;

    localparam logic [7:0] Sync0   = 8'hAA;
    localparam logic [7:0] Sync1   = 8'hAF;
    localparam logic [7:0] FuncAtt = 8'h10;
    localparam logic [7:0] FuncPos = 8'h11;
    localparam logic [7:0] AckId   = 8'hEF;
    localparam logic [7:0] AckLen  = 8'h02;
    localparam logic [7:0] AckBase = 8'(Sync0 + Sync0 + AckId + AckLen);

    // result sequence positions
    localparam logic [3:0] LastWordStep = 4'd8;
    localparam logic [3:0] AckSync0Step = 4'd9;
    localparam logic [3:0] AckSync1Step = 4'd10;
    localparam logic [3:0] AckIdStep    = 4'd11;
    localparam logic [3:0] AckLenStep   = 4'd12;
    localparam logic [3:0] AckFuncStep  = 4'd13;
    localparam logic [3:0] AckSumStep   = 4'd14;
    localparam logic [3:0] AckChkStep   = 4'd15;

    localparam logic KindParam = 1'b0;
    localparam logic KindAck   = 1'b1;

    typedef struct packed {
        logic                       group;
        logic [7:0]                 func;
        logic [7:0]                 sum;
        logic [NumWords-1:0][15:0]  words;
    } pfr_job_t;

    typedef struct packed {
        logic     valid;
        pfr_job_t job;
    } pfr_push_t;

endpackage

// ----- design/pfr_front.sv -----
// ----------------------------------------------------------------------------
// pfr_front
// Byte collector: sync, frame store, running sum and frame check.
// ----------------------------------------------------------------------------
module pfr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              q_full,
    output pfr_pkg::pfr_push_t push
);

    logic [4:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [0:pfr_pkg::SumPos-1];
    logic       completing;
    logic       accept;
    logic       frame_ok;
    logic [7:0] func;

    assign completing = (count_reg >= 5'(pfr_pkg::SumPos));
    assign in_ready   = !completing || !q_full;
    assign accept     = in_valid && in_ready;
    assign func       = store_reg[2];

    assign frame_ok = (sum_reg == in_byte) && (store_reg[0] == pfr_pkg::Sync0)
                   && (store_reg[1] == pfr_pkg::Sync1)
                   && ((func == pfr_pkg::FuncAtt) || (func == pfr_pkg::FuncPos));

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (accept && !(count_reg == 5'd0 && in_byte != pfr_pkg::Sync0))
        begin
            if (completing)
            begin
                count_next = 5'd0;
                sum_next   = 8'd0;
            end
            else
            begin
                count_next = count_reg + 5'd1;
                sum_next   = sum_reg + in_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !completing && !(count_reg == 5'd0 && in_byte != pfr_pkg::Sync0))
        begin
            store_reg[count_reg] <= in_byte;
        end
    end

    assign push.valid     = accept && completing && frame_ok;
    assign push.job.group = (func == pfr_pkg::FuncPos);
    assign push.job.func  = func;
    assign push.job.sum   = sum_reg;

    for (genvar k = 0; k < pfr_pkg::NumWords; k++)
    begin : g_word
        assign push.job.words[k] = {store_reg[4 + 2 * k], store_reg[5 + 2 * k]};
    end

endmodule

// ----- design/pfr_queue.sv -----
// ----------------------------------------------------------------------------
// pfr_queue
// Short queue of checked frames between the collector and the emitter.
// ----------------------------------------------------------------------------
module pfr_queue #(
    parameter int Depth = pfr_pkg::QueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pfr_pkg::pfr_push_t push,
    output logic               full,
    output logic               head_valid,
    output pfr_pkg::pfr_job_t  head,
    input  logic               pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    pfr_pkg::pfr_job_t data_reg [0:Depth-1];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head       = data_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// ----- design/pfr_back.sv -----
// ----------------------------------------------------------------------------
// pfr_back
// Result sequencer: nine parameter words, then the seven-byte acknowledge.
// ----------------------------------------------------------------------------
module pfr_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  pfr_pkg::pfr_job_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_kind,
    output logic              out_group,
    output logic [3:0]        out_index,
    output logic [15:0]       out_value,
    output logic [7:0]        out_tx,
    output logic              out_last
);

    logic [3:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic        kind_reg, group_reg, last_reg;
    logic [3:0]  index_reg;
    logic [15:0] value_reg;
    logic [7:0]  tx_reg;
    logic        load;
    logic        is_word;
    logic [7:0]  ack_byte;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign pop     = load && (step_reg == pfr_pkg::AckChkStep);
    assign is_word = (step_reg <= pfr_pkg::LastWordStep);

    always_comb
    begin
        case (step_reg)
            pfr_pkg::AckSync0Step: ack_byte = pfr_pkg::Sync0;
            pfr_pkg::AckSync1Step: ack_byte = pfr_pkg::Sync0;
            pfr_pkg::AckIdStep:    ack_byte = pfr_pkg::AckId;
            pfr_pkg::AckLenStep:   ack_byte = pfr_pkg::AckLen;
            pfr_pkg::AckFuncStep:  ack_byte = head.func;
            pfr_pkg::AckSumStep:   ack_byte = head.sum;
            pfr_pkg::AckChkStep:   ack_byte = pfr_pkg::AckBase + head.func + head.sum;
            default:               ack_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = step_reg + 4'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= is_word ? pfr_pkg::KindParam : pfr_pkg::KindAck;
            group_reg <= head.group;
            index_reg <= is_word ? step_reg : 4'd0;
            value_reg <= is_word ? head.words[step_reg] : 16'd0;
            tx_reg    <= is_word ? 8'd0 : ack_byte;
            last_reg  <= (step_reg == pfr_pkg::AckChkStep);
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_group = group_reg;
    assign out_index = index_reg;
    assign out_value = value_reg;
    assign out_tx    = tx_reg;
    assign out_last  = last_reg;

endmodule

// ----- design/param_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// param_frame_receiver
// Fixed-length parameter frame receiver with 8-bit additive checksum.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tdata[7:0] rx_byte
//  m_axis    out  tdata index/value/tx, tuser kind/group, tlast last
//
//  One byte is taken per cycle while s_axis_tready is high; bytes keep flowing while results drain.
//  A good frame yields 16 results from the back sequencer, one per cycle while m_axis_tready is high.
//  Up to QueueDepth checked frames wait between collector and sequencer;
//  the completing byte stalls only while that queue is full.
//  rst_n clears the count, the sum, the queue and the output stage.
// ----------------------------------------------------------------------------
module param_frame_receiver #(
    parameter int QueueDepth = pfr_pkg::QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] param_index, [19:4] param_value,
                                        // [27:20] tx_byte, [31:28] zero
    output logic [1:0]  m_axis_tuser,   // [0] kind, [1] param_group
    output logic        m_axis_tlast
);

    pfr_pkg::pfr_push_t push;
    pfr_pkg::pfr_job_t  head;
    logic               q_full;
    logic               head_valid;
    logic               pop;
    logic               out_kind;
    logic               out_group;
    logic [3:0]         out_index;
    logic [15:0]        out_value;
    logic [7:0]         out_tx;

    pfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    pfr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (out_kind),
        .out_group  (out_group),
        .out_index  (out_index),
        .out_value  (out_value),
        .out_tx     (out_tx),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_tx, out_value, out_index};
    assign m_axis_tuser = {out_group, out_kind};

endmodule

// ----- design/pfr_checker.sv -----
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
`include "param_frame_receiver_defines.svh"

module pfr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `PFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
    `PFR_ASSERT_NOW(a_word_form, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:20] == 12'd0 && m_axis_tdata[3:0] <= 4'd8 && !m_axis_tlast, "malformed parameter word")
    `PFR_ASSERT_NOW(a_ack_form, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[19:0] == 20'd0 && m_axis_tdata[31:28] == 4'd0, "malformed acknowledge byte")
    `PFR_ASSERT_NOW(a_last_ack, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "frame end on a parameter word")

endmodule

bind param_frame_receiver pfr_checker u_pfr_checker (.*);
